// ===== hw/rtl/hsc_pkg.sv =====
// Shared types, constants and functions of the Hamming similarity cache.
package hsc_pkg;

    // Fixed field widths of the stream and configuration words.
    localparam int WORD_W   = 64;
    localparam int INDEX_W  = 4;
    localparam int THRESH_W = 17;
    localparam int COUNT_W  = 32;

    // Operation codes carried in the op field.
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Q16 representation of a similarity of one.
    localparam logic [THRESH_W-1:0] Q16_ONE = 17'd65536;
    localparam logic [THRESH_W-1:0] Q16_MAX = 17'd65535;

    // Control word that steers the distance unit for one pair of hash words.
    typedef struct packed {
        logic vld;    // a pair of words is on the data inputs
        logic first;  // first word of an entry
        logic last;   // last word of an entry
        logic flush;  // drop all work in flight
    } t_dist_ctl;

    // Decision for one entry, returned by the distance unit.
    typedef struct packed {
        logic vld;
        logic hit;
    } t_dist_stat;

    // Number of set bits in a 64-bit word.
    function automatic logic [6:0] popcount64(input logic [WORD_W-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + 7'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/hsc_stream_if.sv =====
// Valid/ready stream interfaces for hash words in and lookup results out.
interface hsc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [hsc_pkg::INDEX_W-1:0]  word_index;
    logic [hsc_pkg::WORD_W-1:0]   hash_word;

    modport source (output valid, output op, output word_index, output hash_word,
                    input ready);
    modport sink   (input valid, input op, input word_index, input hash_word,
                    output ready);
endinterface

interface hsc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [hsc_pkg::INDEX_W-1:0]  entry_index;
    logic [hsc_pkg::COUNT_W-1:0]  hit_count;
    logic [hsc_pkg::COUNT_W-1:0]  miss_count;

    modport source (output valid, output hit, output entry_index, output hit_count,
                    output miss_count, input ready);
    modport sink   (input valid, input hit, input entry_index, input hit_count,
                    input miss_count, output ready);
endinterface

// ===== hw/rtl/hsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/hsc_dist_unit.sv =====
// Shared distance unit: XOR popcount, per-entry accumulation and threshold test.
module hsc_dist_unit #(
    parameter int HASH_WORDS = 16,
    parameter int HASH_BITS  = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hsc_pkg::t_dist_ctl             i_ctl,
    input  logic [hsc_pkg::WORD_W-1:0]     i_query_word,
    input  logic [hsc_pkg::WORD_W-1:0]     i_entry_word,
    input  logic [hsc_pkg::THRESH_W-1:0]   i_thresh,
    output hsc_pkg::t_dist_stat            o_stat
);
    localparam int DW  = $clog2(HASH_WORDS * hsc_pkg::WORD_W + 1);
    localparam int BW  = $clog2(HASH_BITS + 1);
    localparam int LW  = hsc_pkg::THRESH_W + BW;
    localparam int SW  = DW + 16;
    localparam int CW  = (LW > SW) ? LW : SW;

    logic [6:0]    r_pc;
    logic          r_a_vld;
    logic          r_a_first;
    logic          r_a_last;
    logic [DW-1:0] r_dist;
    logic          r_fin;
    logic [LW-1:0] r_limit;
    logic          r_thr_zero;
    logic          r_thr_over;
    logic [CW-1:0] dist_scaled;
    logic [CW-1:0] limit_ext;

    // Threshold mapping: sim > thr holds exactly when d*65536 < (65536-thr)*HASH_BITS,
    // with a zero threshold always met and one above full scale never met.
    always_ff @(posedge i_clk) begin
        r_limit    <= LW'(hsc_pkg::THRESH_W'(hsc_pkg::Q16_ONE - i_thresh)) * LW'(HASH_BITS);
        r_thr_zero <= (i_thresh == '0);
        r_thr_over <= (i_thresh > hsc_pkg::Q16_MAX);
    end

    // Popcount stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.flush) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.vld;
        end
        r_a_first <= i_ctl.first;
        r_a_last  <= i_ctl.last;
        r_pc      <= hsc_pkg::popcount64(i_query_word ^ i_entry_word);
    end

    // Accumulation stage: the distance of one entry closes on its last word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.flush) begin
            r_fin <= 1'b0;
        end else begin
            r_fin <= r_a_vld && r_a_last;
        end
        if (r_a_vld) begin
            r_dist <= (r_a_first ? DW'(0) : r_dist) + DW'(r_pc);
        end
    end

    // Threshold test on the finished distance.
    assign dist_scaled = CW'({r_dist, 16'h0000});
    assign limit_ext   = CW'(r_limit);
    assign o_stat.vld  = r_fin;
    assign o_stat.hit  = r_thr_zero || (!r_thr_over && (dist_scaled < limit_ext));
endmodule

// ===== hw/rtl/hamming_similarity_cache_top.sv =====
// Top level of the Hamming similarity cache: word collection, entry store and scan sequencer.
//
//  Channel  Dir  Handshake          Payload
//  i_in     in   valid/ready        op, word_index, hash_word
//  o_out    out  valid/ready        hit, entry_index, hit_count, miss_count
//  i_cfg    in   i_cfg_we (no wait) i_cfg_data = similarity_threshold
//
// A finished insert copies the vector into the entry store. A finished query
// scans the filled entries and stops early on a hit: the entry store's single read
// port delivers one word per cycle to the shared distance unit.
// A query waits to start its scan while a previous result is still held on o_out.
// Reset is synchronous and clears control state only; no clearing pass is run.
module hamming_similarity_cache_top #(
    parameter int HASH_WORDS    = 16,
    parameter int CACHE_ENTRIES = 16,
    parameter int HASH_BITS     = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hsc_in_if.sink                        i_in,
    hsc_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [hsc_pkg::THRESH_W-1:0]  i_cfg_data
);
    localparam int WAW = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
    localparam int BAW = $clog2(2 * HASH_WORDS);
    localparam int SD  = CACHE_ENTRIES * HASH_WORDS;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int EAW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int FW  = $clog2(CACHE_ENTRIES + 1);
    localparam int IW  = (WAW > hsc_pkg::INDEX_W) ? WAW : hsc_pkg::INDEX_W;
    localparam int XW  = (EAW > hsc_pkg::INDEX_W) ? EAW : hsc_pkg::INDEX_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COPY  = 2'd1;
    localparam logic [1:0] S_QWAIT = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]                    r_state;
    logic [hsc_pkg::THRESH_W-1:0]  r_thresh;
    logic [FW-1:0]                 r_fill;
    logic [EAW-1:0]                r_rptr;
    logic [hsc_pkg::COUNT_W-1:0]   r_hits;
    logic [hsc_pkg::COUNT_W-1:0]   r_misses;
    logic                          r_out_vld;
    logic                          r_hit;
    logic [hsc_pkg::INDEX_W-1:0]   r_eidx;
    logic [WAW-1:0]                r_w;
    logic [EAW-1:0]                r_e;
    logic [EAW-1:0]                r_de;
    logic [SAW-1:0]                r_saddr;
    logic                          r_issue;
    logic                          r_cp;
    hsc_pkg::t_dist_ctl            r_pipe;

    logic                          in_acc;
    logic                          idx_ok;
    logic                          idx_last;
    logic [IW-1:0]                 idx_ext;
    logic [WAW-1:0]                widx;
    logic                          buf_we;
    logic [BAW-1:0]                buf_waddr;
    logic [BAW-1:0]                buf_raddr;
    logic [hsc_pkg::WORD_W-1:0]    buf_rdata;
    logic [hsc_pkg::WORD_W-1:0]    store_rdata;
    logic                          w_last;
    logic                          e_last;
    logic                          de_last;
    logic                          scan_end;
    logic [EAW-1:0]                slot;
    logic [XW-1:0]                 de_ext;
    hsc_pkg::t_dist_ctl            dist_ctl;
    hsc_pkg::t_dist_stat           dist_stat;

    // Input word decode.
    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign idx_ok    = (32'(i_in.word_index) < HASH_WORDS);
    assign idx_last  = (32'(i_in.word_index) == HASH_WORDS - 1);
    assign idx_ext   = IW'(i_in.word_index);
    assign widx      = idx_ext[WAW-1:0];

    // Word buffers: query words in the lower half, insert words in the upper half.
    assign buf_we    = in_acc && idx_ok;
    assign buf_waddr = (i_in.op == hsc_pkg::OP_INSERT) ? BAW'(HASH_WORDS) + BAW'(widx)
                                                       : BAW'(widx);
    assign buf_raddr = (r_state == S_COPY) ? BAW'(HASH_WORDS) + BAW'(r_w) : BAW'(r_w);

    hsc_ram #(
        .WIDTH (hsc_pkg::WORD_W),
        .DEPTH (2 * HASH_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (i_in.hash_word),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Entry store: entry e, word w lives at e * HASH_WORDS + w.
    hsc_ram #(
        .WIDTH (hsc_pkg::WORD_W),
        .DEPTH (SD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_cp),
        .i_waddr (r_saddr),
        .i_wdata (buf_rdata),
        .i_raddr (r_saddr),
        .o_rdata (store_rdata)
    );

    // Scan bookkeeping.
    assign w_last   = (r_w == WAW'(HASH_WORDS - 1));
    assign e_last   = (FW'(r_e) + FW'(1) == r_fill);
    assign de_last  = (FW'(r_de) + FW'(1) == r_fill);
    assign scan_end = (r_state == S_SCAN) && dist_stat.vld && (dist_stat.hit || de_last);
    assign de_ext   = XW'(r_de);
    assign slot     = (r_fill < FW'(CACHE_ENTRIES)) ? EAW'(r_fill) : r_rptr;

    // Distance unit control is registered alongside the read data, so it arrives with the word pair it describes.
    always_comb begin
        dist_ctl       = r_pipe;
        dist_ctl.flush = scan_end;
    end

    hsc_dist_unit #(
        .HASH_WORDS (HASH_WORDS),
        .HASH_BITS  (HASH_BITS)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (dist_ctl),
        .i_query_word (buf_rdata),
        .i_entry_word (store_rdata),
        .i_thresh     (r_thresh),
        .o_stat       (dist_stat)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= hsc_pkg::Q16_MAX;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    // Sequencer, slot allocation, counters and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_rptr    <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_out_vld <= 1'b0;
            r_issue   <= 1'b0;
            r_cp      <= 1'b0;
            r_pipe    <= '0;
            r_w       <= '0;
            r_e       <= '0;
            r_de      <= '0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            r_pipe <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && idx_ok && idx_last) begin
                        if (i_in.op == hsc_pkg::OP_INSERT) begin
                            if (r_fill < FW'(CACHE_ENTRIES)) begin
                                r_fill <= r_fill + FW'(1);
                            end else begin
                                r_rptr <= (r_rptr == EAW'(CACHE_ENTRIES - 1)) ? '0
                                                                              : r_rptr + EAW'(1);
                            end
                            r_saddr <= SAW'(slot) * SAW'(HASH_WORDS);
                            r_w     <= '0;
                            r_issue <= 1'b1;
                            r_cp    <= 1'b0;
                            r_state <= S_COPY;
                        end else begin
                            r_state <= S_QWAIT;
                        end
                    end
                end
                S_COPY: begin
                    // Read the insert buffer one word a cycle, write each word in the cycle after its read.
                    r_cp <= r_issue;
                    if (r_issue) begin
                        r_w <= r_w + WAW'(1);
                        if (w_last) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_cp) begin
                        r_saddr <= r_saddr + SAW'(1);
                        if (!r_issue) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_QWAIT: begin
                    // Start only once the previous result has been taken.
                    if (!r_out_vld) begin
                        if (r_fill == '0) begin
                            r_out_vld <= 1'b1;
                            r_hit     <= 1'b0;
                            r_eidx    <= '0;
                            r_misses  <= r_misses + 32'd1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_w     <= '0;
                            r_e     <= '0;
                            r_de    <= '0;
                            r_saddr <= '0;
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one word pair per cycle until the last filled entry or a hit ends the scan.
                    if (r_issue) begin
                        r_pipe.vld   <= 1'b1;
                        r_pipe.first <= (r_w == '0);
                        r_pipe.last  <= w_last;
                        r_saddr      <= r_saddr + SAW'(1);
                        if (w_last) begin
                            r_w <= '0;
                            if (e_last) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_e <= r_e + EAW'(1);
                            end
                        end else begin
                            r_w <= r_w + WAW'(1);
                        end
                    end
                    // Entry decisions return in entry order.
                    if (dist_stat.vld) begin
                        if (scan_end) begin
                            r_out_vld <= 1'b1;
                            r_hit     <= dist_stat.hit;
                            r_eidx    <= dist_stat.hit ? de_ext[hsc_pkg::INDEX_W-1:0] : '0;
                            if (dist_stat.hit) begin
                                r_hits <= r_hits + 32'd1;
                            end else begin
                                r_misses <= r_misses + 32'd1;
                            end
                            r_issue <= 1'b0;
                            r_pipe  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_de <= r_de + EAW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word.
    assign o_out.valid       = r_out_vld;
    assign o_out.hit         = r_hit;
    assign o_out.entry_index = r_eidx;
    assign o_out.hit_count   = r_hits;
    assign o_out.miss_count  = r_misses;

    // A scan decision never lands while an older result is still held.
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && dist_stat.vld) |-> !r_out_vld)
        else $error("scan decision while result register is full");

    // The fill count never passes the number of entries.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CACHE_ENTRIES))
        else $error("fill count beyond cache size");

    // A new result only comes out of a query wait or a scan.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_QWAIT || $past(r_state) == S_SCAN))
        else $error("result produced outside a query");

    // The distance unit stays quiet while an insert is copied.
    a_copy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> !dist_stat.vld)
        else $error("distance decision during insert copy");
endmodule
